// ===== rtl/session_token_table_assert.svh =====
// assertion macros for the session token table
`ifndef SESSION_TOKEN_TABLE_ASSERT_SVH
`define SESSION_TOKEN_TABLE_ASSERT_SVH

`ifndef SYNTHESIS

// checked on every clock edge outside reset
`define STT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define STT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define STT_ASSERT(lbl, prop, msg)
`define STT_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== rtl/stt_pkg.sv =====
// shared types and constants for the session token table
package stt_pkg;

    localparam int unsigned TOKEN_W   = 64;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned ACTIVE_W  = 4;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 32;
    localparam int unsigned SLOT_W    = 3;

    localparam logic [TIME_W-1:0]   DEFAULT_TIMEOUT = 32'd1800;
    localparam logic [ACTIVE_W-1:0] DEFAULT_ACTIVE  = 4'd1;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_SLOTS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT = 2'd1;

    localparam logic MODE_VALIDATE = 1'b0;
    localparam logic MODE_CREATE   = 1'b1;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_UNAUTH = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_EVAL   = 2'd1,
        S_COMMIT = 2'd2
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic eval;
        logic commit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/session_token_table.sv =====
// session token table: login sessions with idle timeout, top level
//
// input channel (i_in_*): one transaction per request. mode 1 creates a session
// with the given token and time in the lowest active slot that is empty or idle
// past the timeout; mode 0 validates a token and refreshes the slot time on a hit.
// output channel (o_out_*): one transaction per request with status
// (ok, table full, unauthorized) and the slot index, zero unless ok.
// configuration: i_cfg_we writes active_slots (index 0) or idle_timeout
// (index 1); write only while no request is in flight.
// timing: a request is captured, all slots are compared in parallel in the
// next cycle, and the commit state then picks the lowest hit, writes the slot
// back and loads the result register. a new request is taken while idle or in
// the commit of the previous one, never during its compare, as compare and
// write-back run in sequence over the shared slot table.
// stall: while a result waits in the output register the next request is
// still taken and compared; its write-back holds until the result is taken.
// reset: all slots are empty, active_slots is 1 and idle_timeout is 1800.
`include "session_token_table_assert.svh"

module session_token_table #(
    parameter int unsigned TABLE_SLOTS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_in_mode,
    input  logic [stt_pkg::TOKEN_W-1:0]   i_in_token,
    input  logic [stt_pkg::TIME_W-1:0]    i_in_now,
    // response channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_out_status,
    output logic [stt_pkg::SLOT_W-1:0]    o_out_slot,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic [stt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [stt_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import stt_pkg::*;

    // command and status between controller and datapath
    t_cmd w_cmd;
    t_sts w_sts;

    // sequencing: idle, compare, write-back
    stt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // slot storage, parallel compare, result register
    stt_dp #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_in_mode    (i_in_mode),
        .i_in_token   (i_in_token),
        .i_in_now     (i_in_now),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_status (o_out_status),
        .o_out_slot   (o_out_slot)
    );

    // a captured request is always compared in the following cycle
    `STT_ASSERT(a_load_then_eval, w_cmd.load |=> w_cmd.eval, "accepted request was not compared")

    // no write-back over a result that is still waiting
    `STT_ASSERT(a_commit_out_free, w_cmd.commit |-> (!o_out_valid || i_out_ready), "result overwritten")

    // a new result only ever comes from a write-back
    `STT_ASSERT(a_out_from_commit, $rose(o_out_valid) |-> $past(w_cmd.commit), "result without write-back")

    // the table is busy while comparing
    `STT_ASSERT_ALWAYS(a_eval_not_ready, w_cmd.eval |-> !o_in_ready, "request taken during compare")

endmodule

// ===== rtl/stt_ctrl.sv =====
// controller state machine for the session token table
module stt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  stt_pkg::t_sts i_sts,
    output stt_pkg::t_cmd o_cmd
);
    import stt_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (i_sts.out_free) begin
                    n_state = i_in_valid ? S_EVAL : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready   = 1'b0;
        o_cmd.eval   = 1'b0;
        o_cmd.commit = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
            end
            S_COMMIT: begin
                o_in_ready   = i_sts.out_free;
                o_cmd.commit = i_sts.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
        o_cmd.load = i_in_valid & o_in_ready;
    end

endmodule

// ===== rtl/stt_dp.sv =====
// slot table, match logic and result register for the session token table
module stt_dp #(
    parameter int unsigned TABLE_SLOTS = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  stt_pkg::t_cmd                    i_cmd,
    output stt_pkg::t_sts                    o_sts,
    input  logic                             i_in_mode,
    input  logic [stt_pkg::TOKEN_W-1:0]      i_in_token,
    input  logic [stt_pkg::TIME_W-1:0]       i_in_now,
    input  logic                             i_cfg_we,
    input  logic [stt_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [stt_pkg::CFG_DAT_W-1:0]    i_cfg_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [1:0]                       o_out_status,
    output logic [stt_pkg::SLOT_W-1:0]       o_out_slot
);
    import stt_pkg::*;

    localparam int unsigned SW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

    // configuration
    logic [ACTIVE_W-1:0] r_active_slots;
    logic [TIME_W-1:0]   r_idle_timeout;

    // captured transaction
    logic               r_mode;
    logic [TOKEN_W-1:0] r_token;
    logic [TIME_W-1:0]  r_now;

    // table
    logic [TABLE_SLOTS-1:0] r_valid;
    logic [TOKEN_W-1:0]     r_slot_token [TABLE_SLOTS];
    logic [TIME_W-1:0]      r_last_seen  [TABLE_SLOTS];

    logic [TABLE_SLOTS-1:0] r_flags;
    logic [TABLE_SLOTS-1:0] n_flags;

    logic [TIME_W-1:0]      w_timeout;
    logic                   w_found;
    logic [SW-1:0]          w_hit;
    logic [SW+2:0]          w_hit_ext;

    logic                   r_out_valid;
    t_status                r_out_status;
    logic [SLOT_W-1:0]      r_out_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_slots <= DEFAULT_ACTIVE;
            r_idle_timeout <= DEFAULT_TIMEOUT;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_ACTIVE_SLOTS) begin
                r_active_slots <= i_cfg_data[ACTIVE_W-1:0];
            end else if (i_cfg_index == CFG_IDLE_TIMEOUT) begin
                r_idle_timeout <= i_cfg_data[TIME_W-1:0];
            end
        end
    end

    assign w_timeout = (r_idle_timeout == '0) ? DEFAULT_TIMEOUT : r_idle_timeout;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= i_in_mode;
            r_token <= i_in_token;
            r_now   <= i_in_now;
        end
    end

    // per-slot candidate flags; slot 0 always counts as active
    always_comb begin
        logic [TIME_W-1:0] elapsed;
        logic              expired;
        logic              in_range;
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            elapsed  = r_now - r_last_seen[i];
            expired  = elapsed > w_timeout;
            in_range = (i == 0) || (i < int'(r_active_slots));
            if (r_mode == MODE_CREATE) begin
                n_flags[i] = in_range & (!r_valid[i] | expired);
            end else begin
                n_flags[i] = in_range & r_valid[i] & !expired
                           & (r_slot_token[i] == r_token);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_flags <= n_flags;
        end
    end

    // lowest flagged slot wins
    always_comb begin
        w_hit = '0;
        for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
            if (r_flags[i]) begin
                w_hit = SW'(i);
            end
        end
    end

    assign w_found   = |r_flags;
    assign w_hit_ext = {3'b000, w_hit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.commit && w_found && r_mode == MODE_CREATE) begin
            r_valid[w_hit] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && w_found) begin
            r_last_seen[w_hit] <= r_now;
            if (r_mode == MODE_CREATE) begin
                r_slot_token[w_hit] <= r_token;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            if (w_found) begin
                r_out_status <= ST_OK;
                r_out_slot   <= w_hit_ext[SLOT_W-1:0];
            end else begin
                r_out_status <= (r_mode == MODE_CREATE) ? ST_FULL : ST_UNAUTH;
                r_out_slot   <= '0;
            end
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_status   = r_out_status;
    assign o_out_slot     = r_out_slot;

endmodule

// ===== dv/session_token_table_checker.sv =====
// reply predictor and scoreboard for the session token table
module session_token_table_checker #(
    parameter int unsigned TABLE_SLOTS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic                          i_in_mode,
    input  logic [stt_pkg::TOKEN_W-1:0]   i_in_token,
    input  logic [stt_pkg::TIME_W-1:0]    i_in_now,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [1:0]                    i_out_status,
    input  logic [stt_pkg::SLOT_W-1:0]    i_out_slot,
    input  logic                          i_cfg_we,
    input  logic [stt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [stt_pkg::CFG_DAT_W-1:0] i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import stt_pkg::*;

    typedef struct {
        t_status            status;
        logic [SLOT_W-1:0]  slot;
    } t_session_reply;

    // shadow copy of the session table and its settings
    bit                    slot_valid     [TABLE_SLOTS];
    logic [TOKEN_W-1:0]    slot_token     [TABLE_SLOTS];
    logic [TIME_W-1:0]     slot_last_seen [TABLE_SLOTS];
    logic [ACTIVE_W-1:0]   active_slots;
    logic [TIME_W-1:0]     idle_timeout;

    t_session_reply expected_replies[$];
    int             fail_count = 0;

    assign o_fail_count = fail_count;

    function automatic bit slot_expired(int idx, logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] elapsed;
        logic [TIME_W-1:0] limit;
        elapsed = now - slot_last_seen[idx];
        limit   = (idle_timeout == '0) ? DEFAULT_TIMEOUT : idle_timeout;
        return elapsed > limit;
    endfunction

    function automatic t_session_reply serve_request(logic mode, logic [TOKEN_W-1:0] token,
                                                     logic [TIME_W-1:0] now);
        int             n;
        int             hit;
        bit             found;
        t_session_reply reply;
        n     = (active_slots == '0) ? 1 : int'(active_slots);
        n     = (n > TABLE_SLOTS) ? TABLE_SLOTS : n;
        hit   = 0;
        found = 1'b0;
        for (int i = 0; i < n && !found; i++) begin
            if (mode == MODE_CREATE) begin
                found = !slot_valid[i] || slot_expired(i, now);
            end else begin
                found = slot_valid[i] && slot_token[i] == token && !slot_expired(i, now);
            end
            if (found) begin
                hit = i;
            end
        end
        if (found) begin
            slot_last_seen[hit] = now;
            if (mode == MODE_CREATE) begin
                slot_valid[hit] = 1'b1;
                slot_token[hit] = token;
            end
        end
        if (found) begin
            reply.status = ST_OK;
        end else begin
            reply.status = (mode == MODE_CREATE) ? ST_FULL : ST_UNAUTH;
        end
        reply.slot = found ? hit[SLOT_W-1:0] : '0;
        return reply;
    endfunction

    always @(posedge i_clk) begin
        t_session_reply want;
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                slot_valid[i] = 1'b0;
            end
            active_slots = DEFAULT_ACTIVE;
            idle_timeout = DEFAULT_TIMEOUT;
            expected_replies.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_ACTIVE_SLOTS) begin
                    active_slots = i_cfg_data[ACTIVE_W-1:0];
                end else if (i_cfg_index == CFG_IDLE_TIMEOUT) begin
                    idle_timeout = i_cfg_data[TIME_W-1:0];
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_replies.size() == 0) begin
                    $error("reply with none expected: status %0d slot %0d",
                           i_out_status, i_out_slot);
                    fail_count++;
                end else begin
                    want = expected_replies.pop_front();
                    if (i_out_status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, i_out_status);
                        fail_count++;
                    end
                    if (i_out_slot !== want.slot) begin
                        $error("slot mismatch: expected %0d, actual %0d",
                               want.slot, i_out_slot);
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_replies.push_back(serve_request(i_in_mode, i_in_token, i_in_now));
            end
        end
        o_pending <= expected_replies.size();
    end

endmodule

// ===== dv/tb.sv =====
// testbench top for the session token table: stimulus, flow control and verdict
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import stt_pkg::*;

    // spare register indexes, writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    // size of the token pool that validates draw from
    localparam int POOL_DEPTH = 12;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic                  in_mode   = MODE_VALIDATE;
    logic [TOKEN_W-1:0]    in_token  = '0;
    logic [TIME_W-1:0]     in_now    = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [1:0]            out_status;
    logic [SLOT_W-1:0]     out_slot;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DAT_W-1:0]  cfg_data  = '0;

    int fail_count;
    int pending_replies;

    // flow control knobs, percent of cycles spent idle
    int sender_idle_pct = 0;
    int recv_idle_pct   = 0;

    // one long receiver stall, armed by the stimulus and timed by the receiver
    logic hold_armed = 1'b0;
    bit   hold_done  = 1'b0;
    int   hold_left  = 0;

    // session clock and tokens already handed to the table
    logic [TIME_W-1:0]  wall_secs = '0;
    logic [TOKEN_W-1:0] issued_tokens[$];

    always #4 clk = ~clk;

    session_token_table u_top (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_in_mode    (in_mode),
        .i_in_token   (in_token),
        .i_in_now     (in_now),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_out_status (out_status),
        .o_out_slot   (out_slot),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    session_token_table_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_mode    (in_mode),
        .i_in_token   (in_token),
        .i_in_now     (in_now),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_status (out_status),
        .i_out_slot   (out_slot),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending_replies)
    );

    // reply side: random ready, or a long hold-off once armed
    always @(posedge clk) begin
        if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_armed && !hold_done) begin
            out_ready <= 1'b0;
            hold_left <= 300;
            hold_done <= 1'b1;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // one request transaction; returns at the edge where it is taken
    task automatic send_request(input logic mode, input logic [TOKEN_W-1:0] token,
                                input logic [TIME_W-1:0] now);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_mode  <= mode;
        in_token <= token;
        in_now   <= now;
        @(posedge clk);
        while (!in_ready) begin
            @(posedge clk);
        end
    endtask

    // stop offering and let every outstanding reply come back
    task automatic wait_for_replies();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_replies != 0) begin
            @(posedge clk);
        end
        // leave a little margin before the next step
        repeat (4) @(posedge clk);
    endtask

    // leaves the write enable high, write_settings lowers it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic write_settings(input logic [CFG_DAT_W-1:0] active,
                                  input logic [CFG_DAT_W-1:0] timeout);
        write_reg(CFG_ACTIVE_SLOTS, active);
        write_reg(CFG_IDLE_TIMEOUT, timeout);
        cfg_we <= 1'b0;
    endtask

    // mostly small time steps, sometimes a jump anywhere or a step backwards
    task automatic issue_random_request();
        logic               mode;
        logic [TOKEN_W-1:0] tok;
        int                 roll;
        roll = $urandom_range(99);
        if (roll < 3) begin
            wall_secs = wall_secs - $urandom_range(50, 1);
        end else if (roll < 8) begin
            wall_secs = $urandom;
        end else begin
            wall_secs = wall_secs + $urandom_range(8);
        end
        mode = ($urandom_range(99) < 45) ? MODE_CREATE : MODE_VALIDATE;
        tok  = {$urandom, $urandom};
        if (mode == MODE_CREATE) begin
            // occasional duplicate token on create
            if (issued_tokens.size() != 0 && $urandom_range(99) < 15) begin
                tok = issued_tokens[$urandom_range(issued_tokens.size() - 1)];
            end
            issued_tokens.push_back(tok);
            if (issued_tokens.size() > POOL_DEPTH) begin
                void'(issued_tokens.pop_front());
            end
        end else if (issued_tokens.size() != 0 && $urandom_range(99) < 80) begin
            tok = issued_tokens[$urandom_range(issued_tokens.size() - 1)];
        end
        send_request(mode, tok, wall_secs);
    endtask

    // run limit, far above the slowest legal run
    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        logic [TOKEN_W-1:0] dir_tok[8];
        logic [CFG_DAT_W-1:0] act;
        logic [CFG_DAT_W-1:0] tmo;
        for (int i = 0; i < 8; i++) begin
            dir_tok[i] = 64'h0123_4567_89AB_CD00 + i;
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: one slot, 1800 s timeout, table empty
        send_request(MODE_VALIDATE, '0, 32'd0);            // nothing stored yet
        send_request(MODE_CREATE, '1, 32'd0);
        send_request(MODE_CREATE, 64'h1234, 32'd5);        // only slot busy, full
        send_request(MODE_VALIDATE, '1, 32'd1800);         // elapsed equals timeout, live
        send_request(MODE_VALIDATE, '1, 32'd3601);         // one past, expired
        send_request(MODE_CREATE, '0, 32'd3601);           // reuses the expired slot
        send_request(MODE_VALIDATE, '0, 32'd3602);
        wait_for_replies();

        // slot count above table size acts as full table, zero timeout acts as default
        write_settings(32'hFFFF_FFFF, 32'd0);
        for (int i = 0; i < 8; i++) begin
            send_request(MODE_CREATE, dir_tok[i], 32'hFFFF_FFF0);
        end
        send_request(MODE_CREATE, 64'h5555_5555_5555_5555, 32'hFFFF_FFF0);
        send_request(MODE_VALIDATE, dir_tok[3], 32'h0000_0010);    // elapsed across wrap
        send_request(MODE_VALIDATE, 64'h8000_0000_0000_0001, 32'h0000_0010);
        wait_for_replies();

        // spare indexes are ignored; largest timeout never expires anything
        write_reg(CFG_SPARE_2, '1);
        write_reg(CFG_SPARE_3, 32'hA5A5_A5A5);
        write_settings(32'd8, 32'hFFFF_FFFF);
        send_request(MODE_CREATE, 64'h0F0F_0F0F_0F0F_0F0F, 32'd0);
        send_request(MODE_VALIDATE, dir_tok[5], 32'hFFFF_FFEF);     // elapsed at maximum
        wait_for_replies();

        // low nibble zero acts as one slot; shortest timeout
        write_settings(32'hABCD_0010, 32'd1);
        send_request(MODE_VALIDATE, dir_tok[0], 32'hFFFF_FFF1);
        send_request(MODE_VALIDATE, dir_tok[0], 32'hFFFF_FFF3);     // idle two, expired
        send_request(MODE_CREATE, dir_tok[1], 32'hFFFF_FFF3);       // duplicate of slot 1
        send_request(MODE_VALIDATE, dir_tok[1], 32'hFFFF_FFF3);
        wait_for_replies();

        // backpressure: receiver holds off while requests keep coming
        write_settings(32'd8, 32'd100);
        hold_armed <= 1'b1;
        repeat (30) issue_random_request();
        wait_for_replies();

        // random traffic under three flow control regimes, four settings each
        for (int r = 0; r < 3; r++) begin
            case (r)
                0: begin
                    sender_idle_pct = 30;
                    recv_idle_pct  <= 61;
                end
                1: begin
                    sender_idle_pct = 61;
                    recv_idle_pct  <= 30;
                end
                default: begin
                    sender_idle_pct = 0;
                    recv_idle_pct  <= 0;
                end
            endcase
            for (int k = 0; k < 4; k++) begin
                wait_for_replies();
                case (k)
                    0: begin
                        act = 32'd1;
                        tmo = $urandom_range(30, 1);
                    end
                    1: begin
                        act = 32'd8;
                        tmo = $urandom_range(300, 5);
                    end
                    2: begin
                        act = $urandom_range(15);
                        tmo = (r == 1) ? 32'hFFFF_FFFF : 32'd0;
                    end
                    default: begin
                        act = $urandom_range(7, 2);
                        tmo = $urandom_range(60, 1);
                    end
                endcase
                write_settings(act, tmo);
                repeat (128) issue_random_request();
            end
        end

        wait_for_replies();
        repeat (10) @(posedge clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/stt_pkg.sv
rtl/stt_ctrl.sv
rtl/stt_dp.sv
rtl/session_token_table.sv
dv/session_token_table_checker.sv
dv/tb.sv
